FILE: hdl/card_id_table_core_assert.svh
// Assertion macros for the card identifier table core.
// Used by card_id_table_core.sv; expects signals clock and reset in scope.
`ifndef CARD_ID_TABLE_CORE_ASSERT_SVH
`define CARD_ID_TABLE_CORE_ASSERT_SVH

// Same-cycle implication.
`define CIT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CIT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/cit_pkg.sv
// Package for the card identifier table: request/response types and command codes.
// No dependencies; used by card_id_table_core.sv.
`default_nettype none

package cit_pkg;

   localparam logic [2:0] CMD_FIND      = 3'd0;
   localparam logic [2:0] CMD_FIND_FREE = 3'd1;
   localparam logic [2:0] CMD_WRITE     = 3'd2;
   localparam logic [2:0] CMD_ERASE_ONE = 3'd3;
   localparam logic [2:0] CMD_ERASE_ALL = 3'd4;

   localparam logic [63:0] EMPTY_ID = '1;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [63:0] card_id;
      logic [6:0]  slot;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [6:0] slot_index;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hdl/card_id_table_core.sv
// Card identifier table: NUM_SLOTS x 64-bit slots searched by one shared comparator.
// Depends on cit_pkg.sv and card_id_table_core_assert.svh.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | cit_pkg::req_type (cmd, card_id, slot)
//   rsp     | out       | rsp_valid/rsp_stall | cit_pkg::rsp_type (found, slot_index)
//
// Find and find-free read the table one slot per cycle through a single read port
// and one 64-bit comparator, passing through the scan, last and done states.
// Write, erase-one, erase-all and unknown commands go straight to the done state.
// Per-slot valid flops let reset and erase-all clear every slot without a scan.
// A response held by rsp_stall blocks only the completion of the next request.
`default_nettype none

module card_id_table_core #(
   parameter int NUM_SLOTS = 128
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire cit_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output cit_pkg::rsp_type      rsp_data
);

   localparam int IDX_W = $clog2(NUM_SLOTS);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_LAST = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [IDX_W-1:0]     addr_ff, addr_in;
   logic [63:0]          key_ff, key_in;
   logic                 last_match_ff, last_match_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic [NUM_SLOTS-1:0] vld_ff, vld_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   cit_pkg::rsp_type     rsp_ff, rsp_in;

   logic [63:0]          mem [NUM_SLOTS];
   logic [63:0]          rd_data_ff;
   logic                 rd_vld_ff;

   logic                 req_acc;
   logic                 in_range;
   logic                 mem_we;
   logic [IDX_W-1:0]     wr_addr;
   logic [63:0]          entry;
   logic                 hit;
   logic                 out_free;
   logic                 find_acc;
   logic                 clear_acc;
   logic                 scanning;
   logic                 rsp_miss;

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign in_range  = (9'(req_data.slot) < 9'(NUM_SLOTS));
   assign wr_addr   = IDX_W'(req_data.slot);
   assign mem_we    = req_acc && (req_data.cmd == cit_pkg::CMD_WRITE) && in_range;
   assign entry     = rd_vld_ff ? rd_data_ff : cit_pkg::EMPTY_ID;
   assign hit       = cmp_vld_ff && (entry == key_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign find_acc  = req_acc && (req_data.cmd == cit_pkg::CMD_FIND);
   assign clear_acc = req_acc && (req_data.cmd == cit_pkg::CMD_ERASE_ALL);
   assign scanning  = (state_ff == S_SCAN) || (state_ff == S_LAST);
   assign rsp_miss  = rsp_valid_ff && !rsp_ff.found;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= req_data.card_id;
      end
      rd_data_ff <= mem[addr_ff];
      rd_vld_ff  <= vld_ff[addr_ff];
   end

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      key_in        = key_ff;
      last_match_in = last_match_ff;
      found_in      = found_ff;
      idx_in        = idx_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = addr_ff;
      vld_in        = vld_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;

      if (hit && (last_match_ff || !found_ff)) begin
         found_in = 1'b1;
         idx_in   = cmp_idx_ff;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               found_in      = 1'b0;
               idx_in        = '0;
               addr_in       = '0;
               last_match_in = 1'b0;
               state_in      = S_DONE;
               case (req_data.cmd)
                  cit_pkg::CMD_FIND: begin
                     key_in        = req_data.card_id;
                     last_match_in = 1'b1;
                     state_in      = S_SCAN;
                  end
                  cit_pkg::CMD_FIND_FREE: begin
                     key_in   = cit_pkg::EMPTY_ID;
                     state_in = S_SCAN;
                  end
                  cit_pkg::CMD_WRITE: begin
                     if (in_range) begin
                        vld_in[wr_addr] = 1'b1;
                     end
                  end
                  cit_pkg::CMD_ERASE_ONE: begin
                     if (in_range) begin
                        vld_in[wr_addr] = 1'b0;
                     end
                  end
                  cit_pkg::CMD_ERASE_ALL: begin
                     vld_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            cmp_vld_in = 1'b1;
            if (addr_ff == IDX_W'(NUM_SLOTS - 1)) begin
               state_in = S_LAST;
            end else begin
               addr_in = addr_ff + IDX_W'(1);
            end
         end
         S_LAST: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.found      = found_ff;
               rsp_in.slot_index = 7'(idx_ff);
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cmp_vld_ff   <= 1'b0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff       <= addr_in;
      key_ff        <= key_in;
      last_match_ff <= last_match_in;
      found_ff      <= found_in;
      idx_ff        <= idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      rsp_ff        <= rsp_in;
   end

`include "card_id_table_core_assert.svh"

   `CIT_ASSERT_NEXT(a_find_scans, find_acc, state_ff == S_SCAN, "find did not start a scan")
   `CIT_ASSERT_NEXT(a_erase_all_clears, clear_acc, vld_ff == '0, "erase-all left a slot valid")
   `CIT_ASSERT_NOW(a_cmp_in_scan, cmp_vld_ff, scanning, "compare outside a scan")
   `CIT_ASSERT_NOW(a_miss_zero_index, rsp_miss, rsp_ff.slot_index == '0, "miss with nonzero index")

endmodule

`default_nettype wire
